// File: design/ppf_pkg.sv
// Shared types and constants of the publish packet framer.
package ppf_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_PUBLISH   = 2'd0;
	localparam logic [1:0] CMD_BODY      = 2'd1;
	localparam logic [1:0] CMD_PING_REQ  = 2'd2;
	localparam logic [1:0] CMD_PING_RESP = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_PUBLISH_TYPE   = 2'd0;
	localparam logic [1:0] REG_PING_REQ_TYPE  = 2'd1;
	localparam logic [1:0] REG_PING_RESP_TYPE = 2'd2;

	// Register reset values
	localparam logic [7:0] PUBLISH_TYPE_RST   = 8'h30;
	localparam logic [7:0] PING_REQ_TYPE_RST  = 8'hC0;
	localparam logic [7:0] PING_RESP_TYPE_RST = 8'hD0;

	// Varint continuation flag
	localparam logic [7:0] VARINT_MORE = 8'h80;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		JOB_BODY,
		JOB_PUBLISH,
		JOB_ERROR,
		JOB_PING
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  first_byte;  // type byte, or body byte for a body job
		logic [10:0] total;       // remaining length of a publish packet
		logic        two_len;     // remaining length takes two varint bytes
		logic [8:0]  tlen;        // topic length
		logic        eop;         // last beat of the job closes the packet
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

// File: design/publish_packet_framer.sv
// An accepted item is queued first; the output sequencer then registers its first beat.
// Throughput: one input beat per cycle while the job queue is not full; body bytes
// leave at one beat per cycle while out_ready holds; a publish header takes 4 or 5
// output beats, a ping 2, an oversize error 1, all from one output sequencer; a
// 4-entry job queue absorbs the difference.
// Reset: arst_n clears the pending body count, queue and output beat and
// restores the type byte registers to 0x30, 0xC0 and 0xD0.
module publish_packet_framer #(
	parameter int BUFFER_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [8:0] topic_length,
	input  logic [8:0] payload_length,
	input  logic [7:0] body_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       end_of_packet,
	output logic       status,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ppf_pkg::queue_status_t q_status;
	ppf_pkg::job_t          push_job;
	ppf_pkg::job_t          head;
	logic                   push;
	logic                   pop;

	ppf_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.topic_length  (topic_length),
		.payload_length(payload_length),
		.body_byte     (body_byte),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_status      (q_status),
		.push          (push),
		.push_job      (push_job)
	);

	ppf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.q_status(q_status)
	);

	ppf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.end_of_packet(end_of_packet),
		.status       (status)
	);

endmodule

// File: design/ppf_front.sv
// Front end: accepts items, tracks pending body bytes and queues jobs.
module ppf_front #(
	parameter int BUFFER_BYTES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [8:0]        topic_length,
	input  logic [8:0]        payload_length,
	input  logic [7:0]        body_byte,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  ppf_pkg::queue_status_t q_status,
	output logic              push,
	output ppf_pkg::job_t     push_job
);

	localparam int LIM_W = $clog2(BUFFER_BYTES + 1);
	localparam int CMP_W = (LIM_W > 12) ? LIM_W : 12;

	logic [7:0]  pub_type_q;
	logic [7:0]  ping_req_type_q;
	logic [7:0]  ping_resp_type_q;
	logic [9:0]  body_left_q;
	logic [9:0]  body_left_d;

	logic        accept;
	logic [9:0]  body_len;
	logic [10:0] total;
	logic        two_len;
	logic [11:0] pkt_size;
	logic        too_big;
	logic        want_push;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	// Size the publish packet
	assign body_len = {1'b0, topic_length} + {1'b0, payload_length};
	assign total    = {1'b0, body_len} + 11'd2;
	assign two_len  = |total[10:7];
	assign pkt_size = {1'b0, total} + (two_len ? 12'd3 : 12'd2);
	assign too_big  = CMP_W'(pkt_size) > CMP_W'(BUFFER_BYTES);

	// Classify the item into a job
	always_comb begin
		want_push           = 1'b0;
		body_left_d         = body_left_q;
		push_job.kind       = ppf_pkg::JOB_BODY;
		push_job.first_byte = body_byte;
		push_job.total      = total;
		push_job.two_len    = two_len;
		push_job.tlen       = topic_length;
		push_job.eop        = 1'b0;
		unique case (cmd)
			ppf_pkg::CMD_PUBLISH: begin
				want_push = 1'b1;
				if (too_big) begin
					push_job.kind       = ppf_pkg::JOB_ERROR;
					push_job.first_byte = 8'h00;
					push_job.eop        = 1'b1;
					body_left_d         = '0;
				end else begin
					push_job.kind       = ppf_pkg::JOB_PUBLISH;
					push_job.first_byte = pub_type_q;
					push_job.eop        = (body_len == 10'd0);
					body_left_d         = body_len;
				end
			end
			ppf_pkg::CMD_BODY: begin
				if (body_left_q != 10'd0) begin
					want_push    = 1'b1;
					push_job.eop = (body_left_q == 10'd1);
					body_left_d  = body_left_q - 10'd1;
				end
			end
			ppf_pkg::CMD_PING_REQ: begin
				want_push           = 1'b1;
				push_job.kind       = ppf_pkg::JOB_PING;
				push_job.first_byte = ping_req_type_q;
				push_job.eop        = 1'b1;
			end
			ppf_pkg::CMD_PING_RESP: begin
				want_push           = 1'b1;
				push_job.kind       = ppf_pkg::JOB_PING;
				push_job.first_byte = ping_resp_type_q;
				push_job.eop        = 1'b1;
			end
		endcase
	end

	assign push = accept && want_push;

	// Hold the pending body count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_left_q <= '0;
		end else if (accept) begin
			body_left_q <= body_left_d;
		end
	end

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_type_q       <= ppf_pkg::PUBLISH_TYPE_RST;
			ping_req_type_q  <= ppf_pkg::PING_REQ_TYPE_RST;
			ping_resp_type_q <= ppf_pkg::PING_RESP_TYPE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ppf_pkg::REG_PUBLISH_TYPE:   pub_type_q       <= cfg_data;
				ppf_pkg::REG_PING_REQ_TYPE:  ping_req_type_q  <= cfg_data;
				ppf_pkg::REG_PING_RESP_TYPE: ping_resp_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: design/ppf_queue.sv
// Short job queue between the front end and the output sequencer.
module ppf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ppf_pkg::job_t          push_job,
	input  logic                   pop,
	output ppf_pkg::job_t          head,
	output ppf_pkg::queue_status_t q_status
);

	ppf_pkg::job_t                 entries_q [ppf_pkg::QUEUE_DEPTH];
	logic [ppf_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ppf_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ppf_pkg::QPTR_W:0]      count_q;

	assign head           = entries_q[rd_ptr_q];
	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == (ppf_pkg::QPTR_W+1)'(ppf_pkg::QUEUE_DEPTH));

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/ppf_back.sv
// Output sequencer: expands queued jobs into packet bytes, one beat per cycle unless stalled.
module ppf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppf_pkg::job_t          head,
	input  ppf_pkg::queue_status_t q_status,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   end_of_packet,
	output logic                   status
);

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       eop_q;
	logic       status_q;

	logic       load;
	logic [7:0] byte_d;
	logic       eop_d;
	logic       status_d;
	logic       last_d;

	assign load = (!out_valid_q || out_ready) && !q_status.empty;
	assign pop  = load && last_d;

	// Pick the byte for the current step of the head job
	always_comb begin
		byte_d   = head.first_byte;
		eop_d    = 1'b0;
		status_d = 1'b0;
		last_d   = 1'b1;
		unique case (head.kind)
			ppf_pkg::JOB_BODY: begin
				eop_d = head.eop;
			end
			ppf_pkg::JOB_ERROR: begin
				byte_d   = 8'h00;
				eop_d    = 1'b1;
				status_d = 1'b1;
			end
			ppf_pkg::JOB_PING: begin
				last_d = (step_q == 3'd1);
				if (step_q != 3'd0) begin
					byte_d = 8'h00;
					eop_d  = 1'b1;
				end
			end
			ppf_pkg::JOB_PUBLISH: begin
				last_d = head.two_len ? (step_q == 3'd4) : (step_q == 3'd3);
				case (step_q)
					3'd0: byte_d = head.first_byte;
					3'd1: byte_d = head.two_len ?
						({1'b0, head.total[6:0]} | ppf_pkg::VARINT_MORE) : head.total[7:0];
					3'd2: byte_d = head.two_len ?
						{4'd0, head.total[10:7]} : {7'd0, head.tlen[8]};
					3'd3: begin
						byte_d = head.two_len ? {7'd0, head.tlen[8]} : head.tlen[7:0];
						eop_d  = !head.two_len && head.eop;
					end
					default: begin
						byte_d = head.tlen[7:0];
						eop_d  = head.eop;
					end
				endcase
			end
		endcase
	end

	// Advance the step and hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			step_q      <= last_d ? 3'd0 : step_q + 3'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_d;
			eop_q      <= eop_d;
			status_q   <= status_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_packet = eop_q;
	assign status        = status_q;

endmodule

// File: design/ppf_checker.sv
// Port-level checks of the publish packet framer, bound to the top level.
module ppf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       end_of_packet,
	input logic       status
);

	// An error beat is a zero byte that closes its packet
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> end_of_packet && (out_byte == 8'h00))
		else $error("error beat without end of packet or with nonzero byte");

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(end_of_packet) && $stable(status))
		else $error("output beat changed while stalled");

	// Back pressure on the input only while output beats are pending
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output beat pending");

endmodule

bind publish_packet_framer ppf_checker u_ppf_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the publish packet framer: directed edge cases and random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_BYTES  = 512;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       eop;
		logic       err;
	} framed_beat_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	logic [8:0] topic_length;
	logic [8:0] payload_length;
	logic [7:0] body_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       end_of_packet;
	logic       status;
	logic       cfg_write;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	// Framer state as the testbench sees it
	logic [7:0] type_publish;
	logic [7:0] type_ping_req;
	logic [7:0] type_ping_resp;
	logic [9:0] pending_body;

	framed_beat_t beats_due[$];
	int  fail_count;
	int  live_items;
	int  n_packets, n_errors, n_pings, n_body, n_beats;
	int  cycles;
	bit  steady;

	publish_packet_framer #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.topic_length(topic_length),
		.payload_length(payload_length),
		.body_byte(body_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.end_of_packet(end_of_packet),
		.status(status),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// End the run once the cycle limit is reached
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d beats outstanding", $time,
				beats_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Toggle output ready in random bursts; hold it high once traffic is steady
	initial begin
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (steady) begin
				out_ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				hold = $urandom_range(0, 23);
			end else begin
				out_ready <= 1'b0;
				hold = $urandom_range(0, 13);
			end
		end
	end

	// Compare each output beat with the oldest predicted beat
	always @(posedge clk) begin
		framed_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			n_beats++;
			if (beats_due.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected beat, expected none, got byte %02h eop %0b status %0b",
					$time, out_byte, end_of_packet, status);
			end else begin
				want = beats_due.pop_front();
				if (out_byte !== want.data || end_of_packet !== want.eop ||
					status !== want.err) begin
					fail_count++;
					$display("%0t: beat mismatch, expected byte %02h eop %0b status %0b, got byte %02h eop %0b status %0b",
						$time, want.data, want.eop, want.err, out_byte, end_of_packet, status);
				end
			end
		end
	end

	function automatic void queue_beat(logic [7:0] data, logic eop, logic err);
		framed_beat_t b;
		b.data = data;
		b.eop  = eop;
		b.err  = err;
		beats_due.push_back(b);
	endfunction

	// Predict the beats that one accepted item produces; return how many
	function automatic int frame_item(logic [1:0] c, logic [8:0] t, logic [8:0] d,
		logic [7:0] b);
		logic [10:0] body_len;
		logic [10:0] total;
		logic        two_len;
		int          pkt;
		int          n;
		n = 0;
		case (c)
			ppf_pkg::CMD_PUBLISH: begin
				body_len = t + d;
				total    = body_len + 11'd2;
				two_len  = (total >= 11'd128);
				pkt      = 1 + (two_len ? 2 : 1) + total;
				if (pkt > BUFFER_BYTES) begin
					pending_body = '0;
					queue_beat(8'h00, 1'b1, 1'b1);
					n = 1;
					n_errors++;
				end else begin
					queue_beat(type_publish, 1'b0, 1'b0);
					if (!two_len) begin
						queue_beat(total[7:0], 1'b0, 1'b0);
						n = 4;
					end else begin
						queue_beat({1'b0, total[6:0]} | ppf_pkg::VARINT_MORE, 1'b0, 1'b0);
						queue_beat({4'b0, total[10:7]}, 1'b0, 1'b0);
						n = 5;
					end
					queue_beat({7'b0, t[8]}, 1'b0, 1'b0);
					queue_beat(t[7:0], body_len == 0, 1'b0);
					pending_body = body_len[9:0];
					n_packets++;
				end
			end
			ppf_pkg::CMD_BODY: begin
				if (pending_body != 0) begin
					pending_body = pending_body - 10'd1;
					queue_beat(b, pending_body == 0, 1'b0);
					n = 1;
					n_body++;
				end
			end
			default: begin
				queue_beat(c == ppf_pkg::CMD_PING_REQ ? type_ping_req : type_ping_resp,
					1'b0, 1'b0);
				queue_beat(8'h00, 1'b1, 1'b0);
				n = 2;
				n_pings++;
			end
		endcase
		return n;
	endfunction

	// Offer one item, wait for the accepting edge, then predict its beats
	task automatic send_item(logic [1:0] c, logic [8:0] t, logic [8:0] d, logic [7:0] b);
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			cmd            <= 2'($urandom_range(0, 3));
			topic_length   <= 9'($urandom_range(0, 511));
			payload_length <= 9'($urandom_range(0, 511));
			body_byte      <= 8'($urandom_range(0, 255));
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= c;
		topic_length   <= t;
		payload_length <= d;
		body_byte      <= b;
		do @(posedge clk); while (!in_ready);
		if (frame_item(c, t, d, b) > 0)
			live_items++;
	endtask

	// Drop valid and wait until every predicted beat has left the framer
	task automatic settle();
		in_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program the three type bytes and poke the unused index
	task automatic set_types(logic [7:0] pub, logic [7:0] req, logic [7:0] resp);
		cfg_write <= 1'b1;
		cfg_index <= ppf_pkg::REG_PUBLISH_TYPE;
		cfg_data  <= pub;
		@(posedge clk);
		type_publish = pub;
		cfg_index <= ppf_pkg::REG_PING_REQ_TYPE;
		cfg_data  <= req;
		@(posedge clk);
		type_ping_req = req;
		cfg_index <= ppf_pkg::REG_PING_RESP_TYPE;
		cfg_data  <= resp;
		@(posedge clk);
		type_ping_resp = resp;
		cfg_index <= REG_UNUSED;
		cfg_data  <= 8'($urandom_range(0, 255));
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_ping();
		send_item($urandom_range(0, 1) ? ppf_pkg::CMD_PING_REQ : ppf_pkg::CMD_PING_RESP,
			9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic send_body();
		send_item(ppf_pkg::CMD_BODY, 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
	endtask

	// Extremes of the lengths, both length sizes, oversize, header and ping inside a body
	task automatic test_edge_cases();
		settle();
		send_item(ppf_pkg::CMD_BODY, 9'h1FF, 9'h1FF, 8'hFF);        // stray body, ignored
		send_item(ppf_pkg::CMD_PING_REQ, 9'h000, 9'h000, 8'h00);
		send_item(ppf_pkg::CMD_PING_RESP, 9'h1FF, 9'h1FF, 8'hFF);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd0, 9'd0, 8'h00);         // empty body
		send_item(ppf_pkg::CMD_PUBLISH, 9'd1, 9'd1, 8'hFF);
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'h00);
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'hFF);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd0, 9'd125, 8'h00);       // longest one-byte length
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'hA5);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd124, 9'd2, 8'h00);       // shortest two-byte length
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'h5A);
		send_item(ppf_pkg::CMD_PING_REQ, 9'd0, 9'd0, 8'h00);        // ping keeps the count
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'h3C);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd511, 9'd511, 8'h00);     // oversize drops the body
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'hC3);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd505, 9'd2, 8'h00);       // exactly fills the buffer
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'h81);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd506, 9'd2, 8'h00);       // one byte too many
		send_item(ppf_pkg::CMD_PUBLISH, 9'd300, 9'd0, 8'h00);       // topic length high byte
		send_item(ppf_pkg::CMD_BODY, 9'd0, 9'd0, 8'h7E);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd511, 9'd0, 8'h00);
		send_item(ppf_pkg::CMD_PUBLISH, 9'd0, 9'd0, 8'h00);
		settle();
	endtask

	// Mostly well-formed packets with random content, plus noise
	task automatic random_traffic(int count);
		int start;
		int pick;
		int t, d, lo;
		start = live_items;
		while (live_items - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 58) begin
				t = $urandom_range(0, 6);
				d = $urandom_range(0, 8);
				send_item(ppf_pkg::CMD_PUBLISH, 9'(t), 9'(d), 8'($urandom_range(0, 255)));
				for (int i = 0; i < t + d; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_ping();
					if ($urandom_range(0, 29) == 0)
						break;
					send_body();
				end
			end else if (pick < 60) begin
				t = $urandom_range(0, 20);
				d = 126 - t + $urandom_range(0, 10);
				send_item(ppf_pkg::CMD_PUBLISH, 9'(t), 9'(d), 8'($urandom_range(0, 255)));
				for (int i = 0; i < t + d; i++)
					send_body();
			end else if (pick < 70) begin
				t  = $urandom_range(0, 511);
				lo = (t >= 508) ? 0 : 508 - t;
				d  = $urandom_range(lo, 511);
				send_item(ppf_pkg::CMD_PUBLISH, 9'(t), 9'(d), 8'($urandom_range(0, 255)));
			end else if (pick < 82) begin
				send_ping();
			end else if (pick < 92) begin
				send_body();
			end else begin
				send_item(ppf_pkg::CMD_PUBLISH, 9'($urandom_range(0, 511)),
					9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_types_all_low();
		settle();
		set_types(8'h00, 8'h00, 8'h00);
		random_traffic(75);
	endtask

	task automatic test_types_all_high();
		settle();
		set_types(8'hFF, 8'hFF, 8'hFF);
		random_traffic(75);
	endtask

	task automatic test_mixed_types();
		settle();
		set_types(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		random_traffic(85);
	endtask

	// Full rate on both sides, no idling
	task automatic test_back_to_back();
		settle();
		set_types(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		steady = 1'b1;
		random_traffic(85);
		settle();
	endtask

	initial begin
		fail_count = 0;
		live_items = 0;
		n_packets = 0;
		n_errors = 0;
		n_pings = 0;
		n_body = 0;
		n_beats = 0;
		cycles = 0;
		steady = 1'b0;
		type_publish   = ppf_pkg::PUBLISH_TYPE_RST;
		type_ping_req  = ppf_pkg::PING_REQ_TYPE_RST;
		type_ping_resp = ppf_pkg::PING_RESP_TYPE_RST;
		pending_body   = '0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		cmd            <= ppf_pkg::CMD_PUBLISH;
		topic_length   <= '0;
		payload_length <= '0;
		body_byte      <= '0;
		cfg_write      <= 1'b0;
		cfg_index      <= ppf_pkg::REG_PUBLISH_TYPE;
		cfg_data       <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_cases();
		test_types_all_low();
		test_types_all_high();
		test_mixed_types();
		test_back_to_back();

		$display("Covered %0d publish headers, %0d oversize errors, %0d pings, %0d body bytes",
			n_packets, n_errors, n_pings, n_body);
		$display("Checked %0d output beats over %0d cycles, %0d failures",
			n_beats, cycles, fail_count);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
